>>> rtl/windowed_sample_statistics_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for windowed_sample_statistics_core
// Shared property forms, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_SAMPLE_STATISTICS_CORE_DEFINES_SVH
`define WINDOWED_SAMPLE_STATISTICS_CORE_DEFINES_SVH

// same-cycle implication
`define WSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/wss_pkg.sv
// ----------------------------------------------------------------------------
// wss_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wss_pkg;

  localparam int SAMPLE_BITS       = 24;
  localparam int CHAN_BITS         = 2;
  localparam int FILL_BITS         = 10;
  localparam int DEF_WINDOW_DEPTH  = 512;
  localparam int DEF_CHANNELS      = 4;

  localparam int IN_FIELD_BITS  = CHAN_BITS + SAMPLE_BITS;
  localparam int IN_DATA_W      = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = CHAN_BITS + 3 * SAMPLE_BITS + FILL_BITS;
  localparam int OUT_DATA_W     = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic latch;
    logic read;
    logic update;
    logic div_start;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_needed;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/wss_ctrl.sv
// ----------------------------------------------------------------------------
// wss_ctrl
// Item sequencer: latch, window read, state update, divide, result load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wss_ctrl #(
  parameter int WINDOW_DEPTH = wss_pkg::DEF_WINDOW_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wss_pkg::stat_t     stat,
  output wss_pkg::cmd_t      cmd
);
  import wss_pkg::*;

  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int STEP_W = $clog2(SUM_W + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_UPDATE = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [STEP_W-1:0] steps;
  logic [STEP_W-1:0] steps_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    steps_next = steps;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.latch  = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        if (stat.div_needed) begin
          cmd.div_start = 1'b1;
          steps_next    = STEP_W'(SUM_W);
          state_next    = S_DIV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        steps_next   = steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      steps <= '0;
    end else begin
      state <= state_next;
      steps <= steps_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/wss_dp.sv
// ----------------------------------------------------------------------------
// wss_dp
// Per-channel window rings, running sums, extremes, restoring divider and
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wss_dp #(
  parameter int WINDOW_DEPTH = wss_pkg::DEF_WINDOW_DEPTH,
  parameter int CHANNELS     = wss_pkg::DEF_CHANNELS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [wss_pkg::IN_DATA_W-1:0] s_tdata,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [wss_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                              m_tuser,
  input  wss_pkg::cmd_t                     cmd,
  output wss_pkg::stat_t                    stat
);
  import wss_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int WP_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SUM_W = SAMPLE_BITS + CNT_W;

  logic [SAMPLE_BITS-1:0] ring [CHANNELS][WINDOW_DEPTH];

  logic [SAMPLE_BITS-1:0] last_value [CHANNELS];
  logic [WP_W-1:0]        wr_ptr     [CHANNELS];
  logic [CNT_W-1:0]       count      [CHANNELS];
  logic [SUM_W-1:0]       sum        [CHANNELS];
  logic [SAMPLE_BITS-1:0] min_seen   [CHANNELS];
  logic [SAMPLE_BITS-1:0] max_seen   [CHANNELS];
  logic [SAMPLE_BITS-1:0] avg_held   [CHANNELS];

  logic [CHAN_BITS-1:0]   ch_r;
  logic [SAMPLE_BITS-1:0] smp_r;
  logic [SAMPLE_BITS-1:0] old_r;
  logic                   acc_r;
  logic                   do_avg;

  logic [SUM_W-1:0]       quo;
  logic [CNT_W-1:0]       rem;
  logic [CNT_W-1:0]       dvs;

  logic [CH_W-1:0]        ch_idx;
  logic                   ch_ok;
  logic                   full;
  logic [CNT_W-1:0]       cnt_next;
  logic [SUM_W-1:0]       sum_next;
  logic [WP_W-1:0]        wp_next;
  logic [CNT_W:0]         rem_sh;
  logic                   ge;

  logic [SAMPLE_BITS-1:0] avg_o;
  logic [SAMPLE_BITS-1:0] min_o;
  logic [SAMPLE_BITS-1:0] max_o;
  logic [FILL_BITS-1:0]   fill_o;

  assign ch_idx = CH_W'(ch_r);
  assign ch_ok  = (32'(ch_r) < CHANNELS);

  assign full     = (count[ch_idx] >= CNT_W'(WINDOW_DEPTH));
  assign cnt_next = full ? count[ch_idx] : count[ch_idx] + 1'b1;
  assign sum_next = sum[ch_idx] - (full ? SUM_W'(old_r) : '0) + SUM_W'(smp_r);
  assign wp_next  = (wr_ptr[ch_idx] == WP_W'(WINDOW_DEPTH - 1)) ? '0
                                                                : wr_ptr[ch_idx] + 1'b1;

  assign stat.div_needed = acc_r && (cnt_next > CNT_W'(1));
  assign stat.out_free   = !m_tvalid || m_tready;

  assign rem_sh = {rem, quo[SUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvs});

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      ch_r  <= s_tdata[CHAN_BITS-1:0];
      smp_r <= s_tdata[CHAN_BITS +: SAMPLE_BITS];
    end
  end

  // window ring: read oldest entry, then overwrite it
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      old_r <= ring[ch_idx][wr_ptr[ch_idx]];
    end
    if (cmd.update && acc_r) begin
      ring[ch_idx][wr_ptr[ch_idx]] <= smp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_r  <= 1'b0;
      do_avg <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        last_value[i] <= '0;
        wr_ptr[i]     <= '0;
        count[i]      <= '0;
        sum[i]        <= '0;
        min_seen[i]   <= '1;
        max_seen[i]   <= '0;
        avg_held[i]   <= '0;
      end
    end else begin
      if (cmd.read) begin
        acc_r <= ch_ok && (smp_r != '0) && (smp_r != last_value[ch_idx]);
      end
      if (cmd.update) begin
        do_avg <= stat.div_needed;
        if (acc_r) begin
          last_value[ch_idx] <= smp_r;
          wr_ptr[ch_idx]     <= wp_next;
          count[ch_idx]      <= cnt_next;
          sum[ch_idx]        <= sum_next;
          if (smp_r < min_seen[ch_idx]) begin
            min_seen[ch_idx] <= smp_r;
          end
          if (smp_r > max_seen[ch_idx]) begin
            max_seen[ch_idx] <= smp_r;
          end
        end
      end
      if (cmd.finish && do_avg) begin
        avg_held[ch_idx] <= quo[SAMPLE_BITS-1:0];
      end
    end
  end

  // restoring divider, one quotient bit per step
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo <= sum_next;
      rem <= '0;
      dvs <= cnt_next;
    end else if (cmd.div_step) begin
      rem <= ge ? CNT_W'(rem_sh - {1'b0, dvs}) : CNT_W'(rem_sh);
      quo <= {quo[SUM_W-2:0], ge};
    end
  end

  always_comb begin
    avg_o  = '0;
    min_o  = '0;
    max_o  = '0;
    fill_o = '0;
    if (ch_ok) begin
      avg_o  = do_avg ? quo[SAMPLE_BITS-1:0] : avg_held[ch_idx];
      min_o  = min_seen[ch_idx];
      max_o  = max_seen[ch_idx];
      fill_o = FILL_BITS'(count[ch_idx]);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tuser <= acc_r;
      m_tdata <= OUT_DATA_W'({fill_o, max_o, min_o, avg_o, ch_r});
    end
  end

endmodule

`default_nettype wire

>>> rtl/windowed_sample_statistics_core.sv
// ----------------------------------------------------------------------------
// windowed_sample_statistics_core
// Per-channel moving average over a sample window with all-time min and max.
// ----------------------------------------------------------------------------
// Each input item carries a channel and a sample; exactly one result item
// comes back per input item, in order. A sample that is zero or repeats the
// channel's last accepted sample is ignored (tuser low) and the current
// statistics are returned. An accepted sample goes through latch, window
// read, state update, divide steps, one per bit of the SUM_W-bit quotient
// (SUM_W = 24 + clog2(WINDOW_DEPTH + 1)), and result load; an ignored
// sample or one that leaves the window at one entry skips the divide. The
// restoring divider for sum / fill count makes one quotient bit per cycle.
// The input is taken again while a result waits in the output
// register; a result is only loaded once the previous one has been taken.
// Window entries live in one ring memory of CHANNELS x WINDOW_DEPTH words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module windowed_sample_statistics_core #(
  parameter int WINDOW_DEPTH = wss_pkg::DEF_WINDOW_DEPTH,
  parameter int CHANNELS     = wss_pkg::DEF_CHANNELS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // channel[1:0], sample[25:2], zero fill above
  input  wire logic [wss_pkg::IN_DATA_W-1:0] s_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // channel_out[1:0], average[25:2], minimum[49:26], maximum[73:50],
  // fill_count[83:74], zero fill above
  output logic [wss_pkg::OUT_DATA_W-1:0]     m_tdata,
  // accepted
  output logic                               m_tuser
);
  import wss_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  wss_ctrl #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wss_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .CHANNELS     (CHANNELS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

`default_nettype wire

>>> rtl/wss_assert.sv
// ----------------------------------------------------------------------------
// wss_assert
// Port-level checks for windowed_sample_statistics_core, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "windowed_sample_statistics_core_defines.svh"

module wss_assert (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic [wss_pkg::IN_DATA_W-1:0]  s_tdata,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [wss_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic                          m_tuser
);
  import wss_pkg::*;

  logic [SAMPLE_BITS-1:0] min_f;
  logic [SAMPLE_BITS-1:0] max_f;
  logic [FILL_BITS-1:0]   fill_f;

  assign min_f     = m_tdata[CHAN_BITS + SAMPLE_BITS +: SAMPLE_BITS];
  assign max_f     = m_tdata[CHAN_BITS + 2 * SAMPLE_BITS +: SAMPLE_BITS];
  assign fill_f    = m_tdata[CHAN_BITS + 3 * SAMPLE_BITS +: FILL_BITS];

  `WSS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
  `WSS_ASSERT_NEXT(a_in_hold, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata), "input item changed while waiting")
  `WSS_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "input taken while an item is in work")
  `WSS_ASSERT_NOW(a_accepted_stats, m_tvalid && m_tuser, (fill_f != '0) && (min_f <= max_f), "accepted result with empty window or min above max")

endmodule

bind windowed_sample_statistics_core wss_assert u_wss_assert (.*);

`default_nettype wire
